@@ hw/rtl/ugli_pkg.sv @@
// shared types and constants for the uniform grid linear interpolator
// no dependencies; imported by ugli_mul and the top level
package ugli_pkg;

  // data path word
  localparam int DATA_W = 32;
  typedef logic [DATA_W-1:0] word_t;

  // default geometry
  localparam int DEF_MAX_POINTS = 256;
  localparam int DEF_FRAC_BITS  = 16;

  // multiplier digit and term limit (magnitudes are capped at 2**TERM_CAP_LOG2)
  localparam int DIGIT_W       = 16;
  localparam int TERM_CAP_LOG2 = 40;

  // input commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_GRID_START    = 3'd0;
  localparam cfg_idx_t CFG_INV_BIN_WIDTH = 3'd1;
  localparam cfg_idx_t CFG_POINT_COUNT   = 3'd2;
  localparam cfg_idx_t CFG_EXTEND_LOW    = 3'd3;
  localparam cfg_idx_t CFG_EXTEND_HIGH   = 3'd4;

endpackage

@@ hw/rtl/ugli_mul.sv @@
// digit-serial unsigned multiplier, one DIGIT_W slice of b per cycle
// depends on ugli_pkg (DIGIT_W)
module ugli_mul #(
  parameter int A_W = 32,
  parameter int B_W = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] product
);
  import ugli_pkg::*;

  localparam int ND    = (B_W + DIGIT_W - 1) / DIGIT_W;
  localparam int B_PAD = ND * DIGIT_W;
  localparam int ACC_W = A_W + B_PAD;
  localparam int CNT_W = $clog2(ND + 1);

  logic [A_W-1:0]         a_reg;
  logic [B_PAD-1:0]       b_reg;
  logic [ACC_W-1:0]       acc;
  logic [CNT_W-1:0]       count;
  logic                   busy;
  logic [A_W+DIGIT_W-1:0] pp;

  // partial product of a with the top remaining digit of b
  assign pp = a_reg * b_reg[B_PAD-1 -: DIGIT_W];

  // digit counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(ND);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand load and shift-accumulate, most significant digit first
  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_reg <= B_PAD'(b);
      acc   <= '0;
    end else if (busy) begin
      acc   <= (acc << DIGIT_W) + ACC_W'(pp);
      b_reg <= b_reg << DIGIT_W;
    end
  end

  assign product = acc[A_W+B_W-1:0];

endmodule

@@ hw/rtl/uniform_grid_linear_interpolator_unit.sv @@
// uniform grid linear interpolator: table memory, sequencer and output register
// depends on ugli_pkg and ugli_mul
//
// usage
// - input channel (in_valid/in_ready): a write beat (command = CMD_WRITE) stores
//   entry_value at entry_index and gives no result; an index at or beyond
//   MAX_POINTS is dropped. an evaluate beat (CMD_EVAL) looks up x_value.
// - output channel (out_valid/out_ready): one beat of y_value and saturated per
//   evaluate, in order. the result sits in an output register, so the next
//   input beat is taken while that result still waits.
// - config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   write registers only while no evaluate is in flight.
// - sequence: with ND = ceil((64 - FRAC_BITS) / 16) digits per multiply, an
//   evaluate makes two passes through the 32 x 16 digit-serial multiplier and
//   two reads on the single table port; the next input beat is taken only once
//   the sequencer is back in idle, so one evaluate ends before the next starts.
// - a stalled receiver holds the sequencer in its last step until the output
//   register frees up; input stays blocked meanwhile.
// - reset clears the sequencer, the output valid and the config registers to
//   their defaults; table entries hold nothing defined until written.
module uniform_grid_linear_interpolator_unit #(
  parameter int MAX_POINTS = ugli_pkg::DEF_MAX_POINTS,
  parameter int FRAC_BITS  = ugli_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic [7:0]                          entry_index,
  input  logic signed [ugli_pkg::DATA_W-1:0]  entry_value,
  input  logic signed [ugli_pkg::DATA_W-1:0]  x_value,
  // output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ugli_pkg::DATA_W-1:0]  y_value,
  output logic                                saturated,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  ugli_pkg::cfg_idx_t                  cfg_index,
  input  ugli_pkg::word_t                     cfg_data
);
  import ugli_pkg::*;

  localparam int AW       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW       = $clog2(MAX_POINTS + 1);
  localparam int CW       = (NW > 9) ? NW : 9;
  localparam int IW       = (AW + 1 > 9) ? AW + 1 : 9;
  localparam int T_W      = 2 * DATA_W - FRAC_BITS;
  localparam int P_W      = DATA_W + T_W;
  localparam int M_FULL_W = P_W - FRAC_BITS;
  localparam int M_W      = TERM_CAP_LOG2 + 1;
  localparam int SUM_W    = TERM_CAP_LOG2 + 2;
  localparam logic [M_FULL_W-1:0] CAP_FULL = M_FULL_W'(1) << TERM_CAP_LOG2;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_ABS_T   = 11'b00000000010,
    S_MUL_T   = 11'b00000000100,
    S_REGION  = 11'b00000001000,
    S_RD_FROM = 11'b00000010000,
    S_RD_TO   = 11'b00000100000,
    S_DIFF    = 11'b00001000000,
    S_ABS_D   = 11'b00010000000,
    S_MUL_D   = 11'b00100000000,
    S_ADD     = 11'b01000000000,
    S_OUT     = 11'b10000000000
  } state_t;

  state_t state, state_next;

  // configuration registers
  word_t      grid_start;
  word_t      inv_bin_width;
  logic [8:0] point_count;
  logic       extend_low_linear;
  logic       extend_high_linear;

  // evaluation registers
  logic [DATA_W:0]   diff;
  logic              diff_le0;
  logic [T_W-1:0]    tq;
  logic [AW-1:0]     to_addr;
  logic              base_to;
  logic              neg;
  logic [T_W-1:0]    bin_dist;
  word_t             from_val;
  word_t             to_val;
  logic [DATA_W:0]   d_val;
  logic              dneg;
  logic [SUM_W-1:0]  sum;

  // table memory
  word_t             sample_table [MAX_POINTS];
  word_t             rd_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [IW-1:0]     idx_ext;
  logic [AW-1:0]     wr_addr;

  // multiplier
  logic              mul_start;
  logic [DATA_W-1:0] mul_a;
  logic [T_W-1:0]    mul_b;
  logic              mul_done;
  logic [P_W-1:0]    mul_product;

  // combinational helpers
  logic              in_accept;
  logic              slot_free;
  logic [CW-1:0]     pc_ext;
  logic [CW-1:0]     n_pts;
  logic [CW-1:0]     n_last;
  logic [CW-1:0]     n_prev;
  logic [T_W-1:0]    last_t;
  logic              at_high;
  logic [T_W-1:0]    high_dist;
  logic [AW-1:0]     idx_i;
  logic [AW-1:0]     from_addr_next;
  logic [AW-1:0]     to_addr_next;
  logic              base_to_next;
  logic              neg_next;
  logic [T_W-1:0]    bin_dist_next;
  logic [DATA_W:0]   mag_full;
  logic [DATA_W:0]   dm_full;
  logic [M_FULL_W-1:0] m_full;
  logic [M_W-1:0]    m_cap;
  logic [SUM_W-1:0]  base_ext;
  logic [SUM_W-1:0]  m_ext;
  word_t             base_val;
  logic              fits;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_start         <= '0;
      inv_bin_width      <= word_t'(65536);
      point_count        <= 9'd2;
      extend_low_linear  <= 1'b0;
      extend_high_linear <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_START:    grid_start         <= cfg_data;
        CFG_INV_BIN_WIDTH: inv_bin_width      <= cfg_data;
        CFG_POINT_COUNT:   point_count        <= cfg_data[8:0];
        CFG_EXTEND_LOW:    extend_low_linear  <= cfg_data[0];
        CFG_EXTEND_HIGH:   extend_high_linear <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // point count clamped to 2 .. MAX_POINTS, grid end in t units
  assign pc_ext  = CW'(point_count);
  assign n_pts   = (pc_ext < CW'(2)) ? CW'(2) :
                   (pc_ext > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : pc_ext;
  assign n_last  = n_pts - CW'(1);
  assign n_prev  = n_pts - CW'(2);
  assign last_t  = T_W'(n_last) << FRAC_BITS;

  // table write port, out-of-range indexes dropped
  assign idx_ext = IW'(entry_index);
  assign wr_addr = idx_ext[AW-1:0];
  assign wr_en   = in_accept && (command == CMD_WRITE) && (idx_ext < IW'(MAX_POINTS));

  // region select: below grid, above grid end, or interior bin
  assign at_high   = (tq >= last_t);
  assign high_dist = tq - last_t;
  assign idx_i     = tq[FRAC_BITS +: AW];

  always_comb begin
    if (diff_le0) begin
      from_addr_next = '0;
      to_addr_next   = AW'(1);
      base_to_next   = 1'b0;
      neg_next       = 1'b1;
      bin_dist_next  = extend_low_linear ? tq : '0;
    end else if (at_high) begin
      from_addr_next = n_prev[AW-1:0];
      to_addr_next   = n_last[AW-1:0];
      base_to_next   = 1'b1;
      neg_next       = 1'b0;
      bin_dist_next  = extend_high_linear ? high_dist : '0;
    end else begin
      from_addr_next = idx_i;
      to_addr_next   = idx_i + AW'(1);
      base_to_next   = 1'b0;
      neg_next       = 1'b0;
      bin_dist_next  = T_W'(tq[FRAC_BITS-1:0]);
    end
  end

  // table read port: lower neighbor first, then upper
  assign rd_en   = (state == S_REGION) || (state == S_RD_FROM);
  assign rd_addr = (state == S_REGION) ? from_addr_next : to_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sample_table[wr_addr] <= entry_value;
    end
    if (rd_en) begin
      rd_data <= sample_table[rd_addr];
    end
  end

  // magnitudes for the two multiplies
  assign mag_full = diff[DATA_W] ? ((DATA_W+1)'(0) - diff) : diff;
  assign dm_full  = d_val[DATA_W] ? ((DATA_W+1)'(0) - d_val) : d_val;

  // shared multiplier: first t, then the bin term
  assign mul_start = (state == S_ABS_T) || (state == S_ABS_D);
  assign mul_a     = (state == S_ABS_T) ? mag_full[DATA_W-1:0] : dm_full[DATA_W-1:0];
  assign mul_b     = (state == S_ABS_T) ? T_W'(inv_bin_width) : bin_dist;

  ugli_mul #(
    .A_W (DATA_W),
    .B_W (T_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_product)
  );

  // scaled term capped, then added to or taken from the base sample
  assign m_full   = mul_product[P_W-1:FRAC_BITS];
  assign m_cap    = (m_full > CAP_FULL) ? CAP_FULL[M_W-1:0] : m_full[M_W-1:0];
  assign base_val = base_to ? to_val : from_val;
  assign base_ext = {{(SUM_W-DATA_W){base_val[DATA_W-1]}}, base_val};
  assign m_ext    = SUM_W'(m_cap);
  assign fits     = (sum[SUM_W-1:DATA_W-1] == '0) || (sum[SUM_W-1:DATA_W-1] == '1);

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_accept && (command == CMD_EVAL)) state_next = S_ABS_T;
      S_ABS_T:   state_next = S_MUL_T;
      S_MUL_T:   if (mul_done) state_next = S_REGION;
      S_REGION:  state_next = S_RD_FROM;
      S_RD_FROM: state_next = S_RD_TO;
      S_RD_TO:   state_next = S_DIFF;
      S_DIFF:    state_next = S_ABS_D;
      S_ABS_D:   state_next = S_MUL_D;
      S_MUL_D:   if (mul_done) state_next = S_ADD;
      S_ADD:     state_next = S_OUT;
      S_OUT:     if (slot_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // evaluation data path registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_accept && command == CMD_EVAL) begin
      diff <= {x_value[DATA_W-1], x_value} - {grid_start[DATA_W-1], grid_start};
    end
    if (state == S_ABS_T) begin
      diff_le0 <= diff[DATA_W] || (diff == '0);
    end
    if (state == S_MUL_T && mul_done) begin
      tq <= mul_product[FRAC_BITS +: T_W];
    end
    if (state == S_REGION) begin
      to_addr  <= to_addr_next;
      base_to  <= base_to_next;
      neg      <= neg_next;
      bin_dist <= bin_dist_next;
    end
    if (state == S_RD_FROM) begin
      from_val <= rd_data;
    end
    if (state == S_RD_TO) begin
      to_val <= rd_data;
    end
    if (state == S_DIFF) begin
      d_val <= {to_val[DATA_W-1], to_val} - {from_val[DATA_W-1], from_val};
    end
    if (state == S_ABS_D) begin
      dneg <= d_val[DATA_W];
    end
    if (state == S_ADD) begin
      sum <= (dneg != neg) ? (base_ext - m_ext) : (base_ext + m_ext);
    end
  end

  // output register with saturation to 32 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && slot_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && slot_free) begin
      saturated <= !fits;
      if (fits) begin
        y_value <= sum[DATA_W-1:0];
      end else if (sum[SUM_W-1]) begin
        y_value <= {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        y_value <= {1'b0, {(DATA_W-1){1'b1}}};
      end
    end
  end

  // checks
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_MUL_T || state == S_MUL_D))
    else $error("multiplier done outside a wait step");

  a_bin_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_REGION && !diff_le0 && !at_high) |-> (CW'(idx_i) < n_last))
    else $error("interior bin index beyond grid end");

  a_eval_starts: assert property (@(posedge clk) disable iff (rst)
    (in_accept && command == CMD_EVAL) |=> (state == S_ABS_T))
    else $error("evaluate beat did not start the sequencer");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (in_accept && command == CMD_WRITE) |=> (state == S_IDLE))
    else $error("write beat left the idle step");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && slot_free) |=> out_valid)
    else $error("result not presented after final step");

endmodule
